// ----- src/ggs_pkg.sv -----
// Shared constants, types and helpers of the grid gradient stencil
`default_nettype none

package ggs_pkg;

   // default grid limits
   localparam int unsigned DefMaxWidth  = 1024;
   localparam int unsigned DefMaxHeight = 1024;

   // field widths
   localparam int unsigned SampleW  = 16;
   localparam int unsigned DiffW    = SampleW + 1;
   localparam int unsigned GainW    = 31;
   localparam int unsigned ProdW    = DiffW + GainW + 1;
   localparam int unsigned GradW    = 50;
   localparam int unsigned DimRegW  = 11;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 31;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_INV_TWO_DX   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_INV_TWO_DY   = 2'd3;

   // item commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   // reset values of the registers
   localparam int unsigned FrameDimReset = 64;
   localparam logic [GainW-1:0] GAIN_RESET = 31'd32768;

   // difference form used along one axis
   typedef enum logic [1:0] {
      DIFF_CENTRAL,
      DIFF_FORWARD,
      DIFF_BACKWARD
   } diff_sel_type;

   // control that travels with an item into the datapath
   typedef struct packed {
      logic         emit;
      logic         last;
      diff_sel_type x_sel;
      diff_sel_type y_sel;
   } item_info_type;

   // saturate a grid dimension into [2, hi]
   function automatic int unsigned clamp_dim(input logic [DimRegW-1:0] v,
                                             input int unsigned hi);
      int unsigned val;
      val = {21'd0, v};
      if (val < 2) begin
         return 2;
      end
      if (val > hi) begin
         return hi;
      end
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- src/ggs_ram.sv -----
// Generic single write port RAM with one registered read port
`default_nettype none

module ggs_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/ggs_ctrl.sv -----
// Registers, raster counters and per-item stencil decisions
`default_nettype none

module ggs_ctrl #(
   parameter int unsigned MAX_WIDTH  = ggs_pkg::DefMaxWidth,
   parameter int unsigned MAX_HEIGHT = ggs_pkg::DefMaxHeight
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_command,
   output logic                               req_stall,
   input  wire logic                          csr_we,
   input  wire logic [ggs_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [ggs_pkg::CsrDataW-1:0]  csr_wdata,
   input  wire logic                          in_ready,
   output logic                               push,
   output ggs_pkg::item_info_type             push_info,
   output logic [$clog2(MAX_WIDTH)-1:0]       push_col,
   output logic [ggs_pkg::GainW-1:0]          gain_dx,
   output logic [ggs_pkg::GainW-1:0]          gain_dy
);

   import ggs_pkg::*;

   localparam int unsigned ColW = $clog2(MAX_WIDTH);
   localparam int unsigned RowW = $clog2(MAX_HEIGHT + 1);
   localparam logic [ColW-1:0] WLastReset =
      ColW'(clamp_dim(DimRegW'(FrameDimReset), MAX_WIDTH) - 1);
   localparam logic [RowW-1:0] HReset =
      RowW'(clamp_dim(DimRegW'(FrameDimReset), MAX_HEIGHT));

   logic [ColW-1:0]  w_last_ff, w_last_in;
   logic [RowW-1:0]  h_ff, h_in;
   logic [GainW-1:0] gain_dx_ff, gain_dx_in;
   logic [GainW-1:0] gain_dy_ff, gain_dy_in;
   logic [ColW-1:0]  line_col_ff, line_col_in;
   logic [RowW-1:0]  samp_row_ff, samp_row_in;
   logic [ColW-1:0]  res_col_ff, res_col_in;
   logic [RowW-1:0]  res_row_ff, res_row_in;

   logic            accept;
   logic            is_drain;
   logic            full;
   logic            samp_act;
   logic            drain_act;
   logic            early;
   logic            emit;
   logic            last;
   logic            res_end_col;
   logic            res_end_row;
   logic            geom_write;
   logic [RowW-1:0] h_last;
   diff_sel_type    x_sel;
   diff_sel_type    y_sel;

   // item decisions
   always_comb begin
      accept      = req_valid && !req_stall;
      is_drain    = (req_command == CMD_DRAIN);
      h_last      = h_ff - RowW'(1);
      full        = (samp_row_ff == h_ff);
      samp_act    = !is_drain && !full;
      drain_act   = is_drain && full;
      early       = (samp_row_ff == '0) ||
                    ((samp_row_ff == RowW'(1)) && (line_col_ff == '0));
      emit        = drain_act || (samp_act && !early);
      res_end_col = (res_col_ff == w_last_ff);
      res_end_row = (res_row_ff == h_last);
      last        = drain_act && res_end_col && res_end_row;

      if (res_col_ff == '0) begin
         x_sel = DIFF_FORWARD;
      end else if (res_end_col) begin
         x_sel = DIFF_BACKWARD;
      end else begin
         x_sel = DIFF_CENTRAL;
      end

      if (res_row_ff == '0) begin
         y_sel = DIFF_FORWARD;
      end else if (res_end_row) begin
         y_sel = DIFF_BACKWARD;
      end else begin
         y_sel = DIFF_CENTRAL;
      end
   end

   assign req_stall       = !in_ready;
   assign push            = accept && (samp_act || drain_act);
   assign push_info.emit  = emit;
   assign push_info.last  = last;
   assign push_info.x_sel = x_sel;
   assign push_info.y_sel = y_sel;
   assign push_col        = line_col_ff;
   assign gain_dx         = gain_dx_ff;
   assign gain_dy         = gain_dy_ff;

   // register writes and counter updates
   always_comb begin
      w_last_in   = w_last_ff;
      h_in        = h_ff;
      gain_dx_in  = gain_dx_ff;
      gain_dy_in  = gain_dy_ff;
      line_col_in = line_col_ff;
      samp_row_in = samp_row_ff;
      res_col_in  = res_col_ff;
      res_row_in  = res_row_ff;
      geom_write  = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_last_in  = ColW'(clamp_dim(csr_wdata[DimRegW-1:0], MAX_WIDTH) - 1);
               geom_write = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               h_in       = RowW'(clamp_dim(csr_wdata[DimRegW-1:0], MAX_HEIGHT));
               geom_write = 1'b1;
            end
            CSR_INV_TWO_DX: begin
               gain_dx_in = csr_wdata[GainW-1:0];
            end
            CSR_INV_TWO_DY: begin
               gain_dy_in = csr_wdata[GainW-1:0];
            end
            default: begin
            end
         endcase
      end

      if (geom_write || (push && last)) begin
         // a new frame starts
         line_col_in = '0;
         samp_row_in = '0;
         res_col_in  = '0;
         res_row_in  = '0;
      end else if (push) begin
         // the line address keeps stepping through drains as well
         if (line_col_ff == w_last_ff) begin
            line_col_in = '0;
            if (samp_act) begin
               samp_row_in = samp_row_ff + RowW'(1);
            end
         end else begin
            line_col_in = line_col_ff + ColW'(1);
         end
         if (emit) begin
            if (res_end_col) begin
               res_col_in = '0;
               res_row_in = res_row_ff + RowW'(1);
            end else begin
               res_col_in = res_col_ff + ColW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= WLastReset;
         h_ff        <= HReset;
         gain_dx_ff  <= GAIN_RESET;
         gain_dy_ff  <= GAIN_RESET;
         line_col_ff <= '0;
         samp_row_ff <= '0;
         res_col_ff  <= '0;
         res_row_ff  <= '0;
      end else begin
         w_last_ff   <= w_last_in;
         h_ff        <= h_in;
         gain_dx_ff  <= gain_dx_in;
         gain_dy_ff  <= gain_dy_in;
         line_col_ff <= line_col_in;
         samp_row_ff <= samp_row_in;
         res_col_ff  <= res_col_in;
         res_row_ff  <= res_row_in;
      end
   end

`ifndef SYNTH
   // sample row count never passes the frame height
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      samp_row_ff <= h_ff)
      else $error("sample row beyond frame height");

   // line address stays inside the frame width
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      line_col_ff <= w_last_ff)
      else $error("line column beyond frame width");

   // results never run ahead of the samples
   a_res_behind: assert property (@(posedge clock) disable iff (reset)
      res_row_ff <= samp_row_ff)
      else $error("result position ahead of sample position");

   // the final result of a frame restarts the counters
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (push && last && !csr_we) |=> (samp_row_ff == '0) && (res_row_ff == '0)
         && (res_col_ff == '0))
      else $error("counters not cleared after frame end");
`endif

endmodule

`default_nettype wire

// ----- src/ggs_datapath.sv -----
// Row delay line, stencil taps, differences and gain multipliers
`default_nettype none

module ggs_datapath #(
   parameter int unsigned MAX_WIDTH = ggs_pkg::DefMaxWidth
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire ggs_pkg::item_info_type             push_info,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]       push_col,
   input  wire logic signed [ggs_pkg::SampleW-1:0] push_sample,
   input  wire logic [ggs_pkg::GainW-1:0]          gain_dx,
   input  wire logic [ggs_pkg::GainW-1:0]          gain_dy,
   output logic                                    in_ready,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [ggs_pkg::GradW-1:0]        rsp_grad_x,
   output logic signed [ggs_pkg::GradW-1:0]        rsp_grad_y,
   output logic                                    rsp_frame_last
);

   import ggs_pkg::*;

   localparam int unsigned ColW = $clog2(MAX_WIDTH);

   typedef struct packed {
      logic last;
      logic double_x;
      logic double_y;
   } diff_info_type;

   // stage 1: item just accepted, first line read in flight
   logic                      s1_valid_ff, s1_valid_in;
   item_info_type             s1_info_ff;
   logic [ColW-1:0]           s1_col_ff;
   logic signed [SampleW-1:0] s1_sample_ff;

   // stage 2: all taps but the oldest row
   logic                      s2_valid_ff, s2_valid_in;
   item_info_type             s2_info_ff;
   logic signed [SampleW-1:0] s2_pw_ff;
   logic signed [SampleW-1:0] s2_p1_ff;
   logic signed [SampleW-1:0] s2_p0_ff;
   logic signed [SampleW-1:0] s2_m1_ff;

   // stage 3: differences
   logic                      s3_valid_ff, s3_valid_in;
   diff_info_type             s3_info_ff, s3_info_in;
   logic signed [DiffW-1:0]   s3_diff_x_ff, s3_diff_x_in;
   logic signed [DiffW-1:0]   s3_diff_y_ff, s3_diff_y_in;

   // result register
   logic                      out_valid_ff, out_valid_in;
   logic signed [GradW-1:0]   out_grad_x_ff, out_grad_x_in;
   logic signed [GradW-1:0]   out_grad_y_ff, out_grad_y_in;
   logic                      out_last_ff;

   // tap history along the raster
   logic signed [SampleW-1:0] prev_ff;
   logic signed [SampleW-1:0] qw1_ff;
   logic signed [SampleW-1:0] qw2_ff;
   logic signed [SampleW-1:0] old_ff;

   logic [SampleW-1:0]        line1_rd;
   logic [SampleW-1:0]        line2_rd;

   logic                      out_load;
   logic                      s3_go;
   logic                      s3_load;
   logic                      s2_go;
   logic                      s2_load;
   logic                      s1_go;

   logic signed [SampleW-1:0] x_hi, x_lo, y_hi, y_lo;
   logic signed [ProdW-1:0]   prod_x, prod_y;
   logic signed [ProdW-1:0]   scaled_x, scaled_y;

   // stage movement, a stage takes a new item when it is empty or moving on
   always_comb begin
      out_load = !out_valid_ff || !rsp_stall;
      s3_go    = s3_valid_ff && out_load;
      s3_load  = !s3_valid_ff || s3_go;
      s2_go    = s2_valid_ff && (!s2_info_ff.emit || s3_load);
      s2_load  = !s2_valid_ff || s2_go;
      s1_go    = s1_valid_ff && s2_load;
      in_ready = !s1_valid_ff || s1_go;

      s1_valid_in  = push || (s1_valid_ff && !s1_go);
      s2_valid_in  = s1_go || (s2_valid_ff && !s2_go);
      s3_valid_in  = (s2_go && s2_info_ff.emit) || (s3_valid_ff && !s3_go);
      out_valid_in = s3_go || (out_valid_ff && rsp_stall);
   end

   // first line: sample one row back
   ggs_ram #(
      .WIDTH (SampleW),
      .DEPTH (MAX_WIDTH)
   ) u_line1 (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (push_col),
      .wr_data (push_sample),
      .rd_en   (push),
      .rd_addr (push_col),
      .rd_data (line1_rd)
   );

   // second line: sample two rows back
   ggs_ram #(
      .WIDTH (SampleW),
      .DEPTH (MAX_WIDTH)
   ) u_line2 (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (line1_rd),
      .rd_en   (s1_go),
      .rd_addr (s1_col_ff),
      .rd_data (line2_rd)
   );

   // stage 3 difference selection
   always_comb begin
      case (s2_info_ff.x_sel)
         DIFF_FORWARD: begin
            x_hi = s2_p1_ff;
            x_lo = s2_p0_ff;
         end
         DIFF_BACKWARD: begin
            x_hi = s2_p0_ff;
            x_lo = s2_m1_ff;
         end
         default: begin
            x_hi = s2_p1_ff;
            x_lo = s2_m1_ff;
         end
      endcase

      case (s2_info_ff.y_sel)
         DIFF_FORWARD: begin
            y_hi = s2_pw_ff;
            y_lo = s2_p0_ff;
         end
         DIFF_BACKWARD: begin
            y_hi = s2_p0_ff;
            y_lo = old_ff;
         end
         default: begin
            y_hi = s2_pw_ff;
            y_lo = old_ff;
         end
      endcase

      s3_diff_x_in        = DiffW'(x_hi) - DiffW'(x_lo);
      s3_diff_y_in        = DiffW'(y_hi) - DiffW'(y_lo);
      s3_info_in.last     = s2_info_ff.last;
      s3_info_in.double_x = (s2_info_ff.x_sel != DIFF_CENTRAL);
      s3_info_in.double_y = (s2_info_ff.y_sel != DIFF_CENTRAL);
   end

   // gain multiply, edge differences take twice the gain
   always_comb begin
      prod_x        = ProdW'(s3_diff_x_ff) * ProdW'($signed({1'b0, gain_dx}));
      prod_y        = ProdW'(s3_diff_y_ff) * ProdW'($signed({1'b0, gain_dy}));
      scaled_x      = s3_info_ff.double_x ? (prod_x <<< 1) : prod_x;
      scaled_y      = s3_info_ff.double_y ? (prod_y <<< 1) : prod_y;
      out_grad_x_in = GradW'(scaled_x);
      out_grad_y_in = GradW'(scaled_y);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the stages and the tap history
   always_ff @(posedge clock) begin
      if (push) begin
         s1_info_ff   <= push_info;
         s1_col_ff    <= push_col;
         s1_sample_ff <= push_sample;
      end
      if (s1_go) begin
         s2_info_ff <= s1_info_ff;
         s2_pw_ff   <= prev_ff;
         s2_p1_ff   <= line1_rd;
         s2_p0_ff   <= qw1_ff;
         s2_m1_ff   <= qw2_ff;
         prev_ff    <= s1_sample_ff;
         qw1_ff     <= line1_rd;
         qw2_ff     <= qw1_ff;
      end
      if (s2_go) begin
         old_ff <= line2_rd;
      end
      if (s2_go && s2_info_ff.emit) begin
         s3_info_ff   <= s3_info_in;
         s3_diff_x_ff <= s3_diff_x_in;
         s3_diff_y_ff <= s3_diff_y_in;
      end
      if (s3_go) begin
         out_grad_x_ff <= out_grad_x_in;
         out_grad_y_ff <= out_grad_y_in;
         out_last_ff   <= s3_info_ff.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_grad_x     = out_grad_x_ff;
   assign rsp_grad_y     = out_grad_y_ff;
   assign rsp_frame_last = out_last_ff;

`ifndef SYNTH
   // a full stage that cannot move keeps the stage before it from passing an item in
   a_s3_blocks_s2: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_go) |-> !(s2_go && s2_info_ff.emit))
      else $error("difference stage overwritten while held");

   // a held result register takes nothing new
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !s3_go)
      else $error("result register overwritten while stalled");

   // no item enters while the first stage is held
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> !push)
      else $error("item accepted into a held first stage");
`endif

endmodule

`default_nettype wire

// ----- src/grid_gradient_stencil.sv -----
// Top level of the streaming two-dimensional gradient stencil
//
// Usage: grid samples of one frame enter on the req_ channel in raster order,
// one item per cycle at most (req_command = sample). The X and Y gradient of
// point p comes out on the rsp_ channel when sample p+W+1 is taken; after
// the frame's last sample, W+1 drain items (req_command = drain) push out
// the remaining results, and the final one carries rsp_frame_last.
// Samples beyond a full frame and drains before it is full are taken and
// dropped. Geometry and gain registers are written on the csr_ port while
// the block is idle; a geometry write starts a new frame.
// An item taken passes stage 1, stage 2, the difference stage and the result
// register before its result is on rsp_grad_x/rsp_grad_y. Throughput:
// one item per cycle while req_stall is low, set by the two row line RAMs (one
// write and one read each per item) and the four-stage pipeline behind them.
// Stall: a stalled result holds in the output register; the stages behind it
// keep filling, and req_stall rises only when every stage is occupied.
// Reset: counters and valid bits clear and the registers return to
// 64 x 64 with unit grid spacing (gains of one half); the line RAMs need no
// clearing.
`default_nettype none

module grid_gradient_stencil #(
   parameter int unsigned MAX_WIDTH  = ggs_pkg::DefMaxWidth,
   parameter int unsigned MAX_HEIGHT = ggs_pkg::DefMaxHeight
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_command,
   input  wire logic signed [ggs_pkg::SampleW-1:0] req_sample,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [ggs_pkg::GradW-1:0]        rsp_grad_x,
   output logic signed [ggs_pkg::GradW-1:0]        rsp_grad_y,
   output logic                                    rsp_frame_last,
   input  wire logic                               csr_we,
   input  wire logic [ggs_pkg::CsrIdxW-1:0]        csr_index,
   input  wire logic [ggs_pkg::CsrDataW-1:0]       csr_wdata
);

   import ggs_pkg::*;

   logic                         push;
   item_info_type                push_info;
   logic [$clog2(MAX_WIDTH)-1:0] push_col;
   logic [GainW-1:0]             gain_dx;
   logic [GainW-1:0]             gain_dy;
   logic                         in_ready;

   // counters, registers and item decisions
   ggs_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_ready    (in_ready),
      .push        (push),
      .push_info   (push_info),
      .push_col    (push_col),
      .gain_dx     (gain_dx),
      .gain_dy     (gain_dy)
   );

   // line buffers and arithmetic pipeline
   ggs_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .push_info      (push_info),
      .push_col       (push_col),
      .push_sample    (req_sample),
      .gain_dx        (gain_dx),
      .gain_dy        (gain_dy),
      .in_ready       (in_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench of the grid gradient stencil: directed frames, random frames, stalls
`timescale 1ns / 1ps

module tb;
   import ggs_pkg::*;

   localparam int unsigned MaxW       = DefMaxWidth;
   localparam int unsigned MaxH       = DefMaxHeight;
   localparam int unsigned LineDepth  = 2 * MaxW + 1;
   localparam int unsigned DrainWait  = 8;
   localparam int unsigned CycleLimit = 100000;
   localparam int unsigned MaxPrinted = 40;
   localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
   localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

   typedef struct packed {
      logic signed [GradW-1:0] grad_x;
      logic signed [GradW-1:0] grad_y;
      logic                    frame_last;
   } gradient_type;

   // block ports
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic                      req_command = CMD_SAMPLE;
   logic signed [SampleW-1:0] req_sample  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic signed [GradW-1:0]   rsp_grad_x;
   logic signed [GradW-1:0]   rsp_grad_y;
   logic                      rsp_frame_last;
   logic                      csr_we      = 1'b0;
   logic [CsrIdxW-1:0]        csr_index   = CSR_FRAME_WIDTH;
   logic [CsrDataW-1:0]       csr_wdata   = '0;

   // gradient predictor state
   logic signed [SampleW-1:0] field_line [LineDepth];
   int unsigned               samples_in_frame = 0;
   int unsigned               grads_in_frame   = 0;
   logic [DimRegW-1:0]        width_reg  = DimRegW'(FrameDimReset);
   logic [DimRegW-1:0]        height_reg = DimRegW'(FrameDimReset);
   logic [GainW-1:0]          gain_x     = GAIN_RESET;
   logic [GainW-1:0]          gain_y     = GAIN_RESET;
   gradient_type              expected_grads [$];

   // run control and bookkeeping
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int unsigned     error_count   = 0;
   int unsigned     checked_count = 0;
   int unsigned     useful_items  = 0;
   int unsigned     ignored_items = 0;
   int unsigned     csr_writes    = 0;
   longint unsigned cycle_count   = 0;

   grid_gradient_stencil dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // geometry in use: saturated into [2, hi]
   function automatic int unsigned used_dim(input logic [DimRegW-1:0] v, input int unsigned hi);
      int unsigned d;
      d = {21'd0, v};
      if (d < 2) begin
         return 2;
      end
      if (d > hi) begin
         return hi;
      end
      return d;
   endfunction

   function automatic int line_tap(input int unsigned pos);
      return int'(field_line[pos % LineDepth]);
   endfunction

   // one axis: difference times gain, doubled for one-sided borders
   function automatic logic signed [GradW-1:0] axis_grad(input int lo_tap, input int hi_tap,
                                                         input logic [GainW-1:0] gain,
                                                         input bit one_sided);
      longint g;
      longint prod;
      g = longint'(gain);
      prod = longint'(hi_tap - lo_tap) * g;
      if (one_sided) begin
         prod = prod * 2;
      end
      return prod[GradW-1:0];
   endfunction

   function automatic gradient_type grad_at(input int unsigned p, input int unsigned w,
                                            input int unsigned h);
      gradient_type r;
      int unsigned  col;
      int unsigned  row;
      col = p % w;
      row = p / w;
      if (col == 0) begin
         r.grad_x = axis_grad(line_tap(p), line_tap(p + 1), gain_x, 1'b1);
      end else if (col == w - 1) begin
         r.grad_x = axis_grad(line_tap(p - 1), line_tap(p), gain_x, 1'b1);
      end else begin
         r.grad_x = axis_grad(line_tap(p - 1), line_tap(p + 1), gain_x, 1'b0);
      end
      if (row == 0) begin
         r.grad_y = axis_grad(line_tap(p), line_tap(p + w), gain_y, 1'b1);
      end else if (row == h - 1) begin
         r.grad_y = axis_grad(line_tap(p - w), line_tap(p), gain_y, 1'b1);
      end else begin
         r.grad_y = axis_grad(line_tap(p - w), line_tap(p + w), gain_y, 1'b0);
      end
      r.frame_last = 1'b0;
      return r;
   endfunction

   // update the predictor for one accepted item and queue its gradient, if any
   function automatic void predict_item(input logic cmd, input logic signed [SampleW-1:0] smp);
      int unsigned  w;
      int unsigned  h;
      int unsigned  total;
      gradient_type r;
      w = used_dim(width_reg, MaxW);
      h = used_dim(height_reg, MaxH);
      total = w * h;
      if (cmd == CMD_SAMPLE) begin
         if (samples_in_frame >= total) begin
            ignored_items++;
            return;
         end
         if (samples_in_frame >= w + 1) begin
            expected_grads.push_back(grad_at(samples_in_frame - w - 1, w, h));
            grads_in_frame++;
         end
         field_line[samples_in_frame % LineDepth] = smp;
         samples_in_frame++;
         useful_items++;
      end else if (samples_in_frame < total || grads_in_frame >= total) begin
         ignored_items++;
      end else begin
         r = grad_at(grads_in_frame, w, h);
         grads_in_frame++;
         if (grads_in_frame == total) begin
            r.frame_last = 1'b1;
            samples_in_frame = 0;
            grads_in_frame = 0;
         end
         expected_grads.push_back(r);
         useful_items++;
      end
   endfunction

   function automatic logic signed [SampleW-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return SampleMax;
         1: return SampleMin;
         2: return '0;
         default: return SampleW'($urandom);
      endcase
   endfunction

   function automatic logic [CsrDataW-1:0] rand_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return GAIN_RESET;
         3, 4: return CsrDataW'($urandom);
         default: return CsrDataW'($urandom_range(1, 1 << 20));
      endcase
   endfunction

   // mostly small sizes, sometimes below the floor or with junk above the field
   function automatic logic [CsrDataW-1:0] rand_dim(input int unsigned hi);
      logic [CsrDataW-1:0] v;
      case ($urandom_range(0, 19))
         0: v = '0;
         1: v = CsrDataW'(1);
         2: begin
            v = CsrDataW'($urandom);
            v[DimRegW-1:0] = DimRegW'($urandom_range(2, hi));
         end
         default: v = CsrDataW'($urandom_range(2, hi));
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < MaxPrinted) begin
         $display("ERROR result %0d: %s, got %0d expected %0d", checked_count, what, got, want);
      end
      error_count++;
   endtask

   // send one item, wait for it to be taken, then predict
   task automatic send_item(input logic cmd, input logic signed [SampleW-1:0] smp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_sample  <= smp;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      predict_item(cmd, smp);
   endtask

   task automatic send_samples(input int unsigned n);
      repeat (n) send_item(CMD_SAMPLE, rand_sample());
   endtask

   task automatic send_drains(input int unsigned n);
      repeat (n) send_item(CMD_DRAIN, rand_sample());
   endtask

   // block idle: every expected gradient out and the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_grads.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH: begin
            width_reg = data[DimRegW-1:0];
            samples_in_frame = 0;
            grads_in_frame = 0;
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = data[DimRegW-1:0];
            samples_in_frame = 0;
            grads_in_frame = 0;
         end
         CSR_INV_TWO_DX: gain_x = data[GainW-1:0];
         CSR_INV_TWO_DY: gain_y = data[GainW-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CsrDataW-1:0] w, input logic [CsrDataW-1:0] h);
      settle();
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic set_gains(input logic [CsrDataW-1:0] gx, input logic [CsrDataW-1:0] gy);
      settle();
      csr_write(CSR_INV_TWO_DX, gx);
      csr_write(CSR_INV_TWO_DY, gy);
   endtask

   // reset geometry and gains: a few points of a 64-wide frame
   task automatic test_reset_defaults();
      send_samples(67);
   endtask

   // largest differences at the largest gains, then zero gains
   task automatic test_field_extremes();
      int k;
      set_geometry(3, 3);
      set_gains('1, '1);
      // checkerboard: largest one-sided steps of both signs
      for (k = 0; k < 9; k++) begin
         send_item(CMD_SAMPLE, ((k % 3 + k / 3) % 2 == 0) ? SampleMax : SampleMin);
      end
      send_drains(4);
      // low corner, high far column and row: largest central steps
      for (k = 0; k < 9; k++) begin
         send_item(CMD_SAMPLE, (k % 3 == 2 || k / 3 == 2) ? SampleMax : SampleMin);
      end
      send_drains(4);
      set_geometry(2, 2);
      set_gains(0, 0);
      send_samples(4);
      send_drains(3);
   endtask

   // saturated geometry, dropped items, frame end and abandoned frame
   task automatic test_edge_cases();
      set_geometry(0, 1);
      set_gains(rand_gain(), rand_gain());
      send_drains(1);   // nothing pending
      send_samples(2);
      send_drains(1);   // frame not yet full
      send_samples(2);
      send_samples(1);  // frame full, dropped
      send_drains(3);
      send_drains(1);   // after frame end
      send_samples(3);
      settle();
      csr_write(CSR_FRAME_HEIGHT, 1);
      send_samples(4);
      send_drains(3);
   endtask

   // widest frame from an oversized width: the first points of row 0,
   // the partial frame is dropped by the next geometry write
   task automatic test_max_width();
      set_geometry(2047, 2);
      set_gains(rand_gain(), rand_gain());
      send_samples(MaxW + 8);
   endtask

   // tallest frame from an oversized height: the first rows only
   task automatic test_max_height();
      set_geometry(2, 2047);
      send_samples(16);
   endtask

   // mostly whole frames with random content, some noise and broken frames
   task automatic run_random_frames(input int unsigned target);
      int unsigned stop_at;
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned k;
      stop_at = useful_items + target;
      // start from a fresh small frame
      set_geometry(rand_dim(8), rand_dim(6));
      while (useful_items < stop_at) begin
         if ($urandom_range(0, 99) < 60) begin
            set_geometry(rand_dim(8), rand_dim(6));
         end
         if ($urandom_range(0, 99) < 30) begin
            set_gains(rand_gain(), rand_gain());
         end
         w = used_dim(width_reg, MaxW);
         h = used_dim(height_reg, MaxH);
         total = w * h;
         if ($urandom_range(0, 99) < 10) begin
            // partial frame dropped by a geometry write
            send_samples($urandom_range(1, total - 1));
            set_geometry(rand_dim(8), rand_dim(6));
         end else begin
            for (k = 0; k < total; k++) begin
               if ($urandom_range(0, 99) < 4) begin
                  send_drains(1);
               end
               if (k == total / 2 && $urandom_range(0, 99) < 8) begin
                  set_gains(rand_gain(), rand_gain());
               end
               send_item(CMD_SAMPLE, rand_sample());
            end
            if ($urandom_range(0, 99) < 10) begin
               send_samples($urandom_range(1, 3));
            end
            send_drains(w + 1);
            if ($urandom_range(0, 99) < 10) begin
               send_drains(1);
            end
         end
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // compare each gradient taken with the oldest prediction
   always @(posedge clock) begin : check_results
      gradient_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_grads.size() == 0) begin
            report_mismatch("result with nothing expected, grad_x", rsp_grad_x, 0);
         end else begin
            want = expected_grads.pop_front();
            if (rsp_grad_x !== want.grad_x) begin
               report_mismatch("grad_x", rsp_grad_x, want.grad_x);
            end
            if (rsp_grad_y !== want.grad_y) begin
               report_mismatch("grad_y", rsp_grad_y, want.grad_y);
            end
            if (rsp_frame_last !== want.frame_last) begin
               report_mismatch("frame_last", rsp_frame_last, want.frame_last);
            end
         end
         checked_count++;
      end
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("run stopped at cycle limit %0d", CycleLimit);
         $display("FAIL grid_gradient_stencil");
         $finish;
      end
   end

   // test sequence
   initial begin
      send_idle_pct = 8;
      recv_idle_pct = 45;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_edge_cases();
      run_random_frames(40);

      send_idle_pct = 45;
      recv_idle_pct = 8;
      run_random_frames(40);
      test_max_width();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_frames(40);
      test_max_height();

      settle();
      $display("checked %0d gradients from %0d items, %0d items dropped, %0d register writes",
               checked_count, useful_items + ignored_items, ignored_items, csr_writes);
      $display("geometry from 2x2 up to the %0d x %0d limits under three stall patterns",
               MaxW, MaxH);
      if (error_count == 0) begin
         $display("PASS grid_gradient_stencil");
      end else begin
         $display("FAIL grid_gradient_stencil");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/ggs_pkg.sv
src/ggs_ram.sv
src/ggs_ctrl.sv
src/ggs_datapath.sv
src/grid_gradient_stencil.sv
tb/sv/tb.sv
